// ===== rtl/core/rgchi_pkg.sv =====
// shared types and constants for the rg chromaticity histogram intersection block
// no dependencies
package rgchi_pkg;

	localparam int BINS_PER_AXIS_DEF = 16;
	localparam int COUNT_BITS_DEF    = 22;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int CHAN_W = 8;
	localparam int SUM_W  = 10;
	localparam int OUT_W  = 17;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BIN,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_SW_RD,
		ST_SW_GO,
		ST_SW_DIV,
		ST_SW_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic cnt_rd;
		logic cnt_wr;
		logic norm_start;
		logic sw_wr;
		logic idx_step;
		logic acc_clr;
		logic total_clr;
		logic set_valid;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic bin_done;
		logic norm_done;
		logic idx_last;
		logic req;
		logic last;
	} status_t;

endpackage

// ===== rtl/core/rgchi_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module rgchi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/rgchi_div.sv =====
// restoring divider, one quotient bit per cycle
// caller guarantees dividend < divisor * 2^QW; no dependencies
module rgchi_div #(
	parameter int XW = 16,
	parameter int DW = 11,
	parameter int QW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quotient,
	output logic          done
);

	localparam int SW = DW + QW - 1;
	localparam int CW = (XW > SW) ? XW : SW;
	localparam int NW = $clog2(QW + 1);

	logic [XW-1:0] rem_q;
	logic [SW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] rem_w;
	logic [CW-1:0] dsh_w;
	logic          ge;

	assign rem_w = CW'(rem_q);
	assign dsh_w = CW'(dsh_q);
	assign ge    = rem_w >= dsh_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == NW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= SW'(divisor) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= XW'(rem_w - dsh_w);
			end
			quo_q <= (quo_q << 1) | QW'(ge);
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/rgchi_ctrl.sv =====
// controller state machine: reset clearing pass, pixel binning, end of image sweep, result hand-off
// depends on rgchi_pkg
module rgchi_ctrl
	import rgchi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (st.idx_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_BIN;
			ST_BIN:    if (st.bin_done) state_d = ST_CNT_RD;
			ST_CNT_RD: state_d = ST_CNT_WR;
			ST_CNT_WR: state_d = st.last ? ST_SW_RD : ST_IDLE;
			ST_SW_RD:  state_d = ST_SW_GO;
			ST_SW_GO:  state_d = ST_SW_DIV;
			ST_SW_DIV: if (st.norm_done) state_d = ST_SW_WR;
			ST_SW_WR:  state_d = st.idx_last ? ST_FINISH : ST_SW_RD;
			ST_FINISH: if (!st.req || out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr   = 1'b1;
				cmd.idx_step = 1'b1;
			end
			ST_IDLE:   cmd.accept = in_valid;
			ST_CNT_RD: cmd.cnt_rd = 1'b1;
			ST_CNT_WR: begin
				cmd.cnt_wr  = 1'b1;
				cmd.acc_clr = 1'b1;
			end
			ST_SW_GO:  cmd.norm_start = 1'b1;
			ST_SW_WR: begin
				cmd.sw_wr    = 1'b1;
				cmd.idx_step = 1'b1;
			end
			ST_FINISH: begin
				if (!st.req) begin
					cmd.set_valid = 1'b1;
					cmd.total_clr = 1'b1;
				end else if (out_free) begin
					cmd.out_load  = 1'b1;
					cmd.total_clr = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken word");
	a_sweep_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SW_WR && !st.idx_last) |=> (state_q == ST_SW_RD))
		else $error("sweep left early");
	a_bin_done: assert property (@(posedge clk) disable iff (!arst_n)
		st.bin_done |-> (state_q == ST_BIN))
		else $error("bin divider finished outside binning");
	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		st.norm_done |-> (state_q == ST_SW_DIV))
		else $error("normalize divider finished outside sweep");
`endif

endmodule

// ===== rtl/core/rgchi_dp.sv =====
// datapath: bin dividers, count and target memories, normalize divider, accumulator
// depends on rgchi_pkg, rgchi_div, rgchi_ram
module rgchi_dp
	import rgchi_pkg::*;
#(
	parameter int BINS_PER_AXIS = BINS_PER_AXIS_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic              req_type,
	input  logic [CHAN_W-1:0] blue,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] red,
	input  logic              last_pixel,
	output logic [OUT_W-1:0]  intersection,
	output logic              target_loaded
);

	localparam int M        = BINS_PER_AXIS - 1;
	localparam int NUM_BINS = BINS_PER_AXIS * BINS_PER_AXIS;
	localparam int IDX_W    = $clog2(NUM_BINS);
	localparam int QB       = $clog2(BINS_PER_AXIS);
	localparam int NUM_W    = $clog2(2 * M * 255 + 766);
	localparam int DEN_W    = SUM_W + 1;
	localparam int CNT_W    = COUNT_BITS + 1;
	localparam int VAL_W    = FRACTION_BITS + 1;
	localparam int NX_W     = CNT_W + FRACTION_BITS;
	localparam int ACC_W    = ((VAL_W > OUT_W) ? VAL_W : OUT_W) + 1;
	localparam logic [ACC_W-1:0] OUT_MAX = ACC_W'((64'd1 << OUT_W) - 64'd1);

	logic [SUM_W-1:0] sum;
	logic [NUM_W-1:0] num_r;
	logic [NUM_W-1:0] num_g;
	logic [DEN_W-1:0] den;
	logic [QB-1:0]    row;
	logic [QB-1:0]    col;
	logic             row_done;
	logic             col_done;
	logic [IDX_W-1:0] idx_pix;
	logic [IDX_W-1:0] idx_q;
	logic             zero_q;
	logic             req_q;
	logic             last_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] cnt_rdata;
	logic [CNT_W-1:0] cnt_inc;
	logic             cnt_we;
	logic [IDX_W-1:0] cnt_waddr;
	logic [CNT_W-1:0] cnt_wdata;
	logic [IDX_W-1:0] cnt_raddr;
	logic [VAL_W-1:0] tgt_rdata;
	logic             tgt_we;
	logic [VAL_W-1:0] tgt_wdata;
	logic [VAL_W-1:0] t_q;
	logic [VAL_W-1:0] norm;
	logic             norm_done;
	logic [VAL_W-1:0] min_v;
	logic [ACC_W-1:0] acc_sum;
	logic [ACC_W-1:0] acc_q;
	logic [OUT_W-1:0] result_q;
	logic             tvalid_q;
	logic             tloaded_q;

	assign sum   = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
	assign num_r = NUM_W'(NUM_W'(red) * NUM_W'(2 * M)) + NUM_W'(sum);
	assign num_g = NUM_W'(NUM_W'(green) * NUM_W'(2 * M)) + NUM_W'(sum);
	assign den   = {sum, 1'b0};

	rgchi_div #(.XW(NUM_W), .DW(DEN_W), .QW(QB)) u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept),
		.dividend (num_r),
		.divisor  (den),
		.quotient (row),
		.done     (row_done)
	);

	rgchi_div #(.XW(NUM_W), .DW(DEN_W), .QW(QB)) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept),
		.dividend (num_g),
		.divisor  (den),
		.quotient (col),
		.done     (col_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			zero_q <= (sum == '0);
			req_q  <= req_type;
			last_q <= last_pixel;
		end
		if (cmd.norm_start) begin
			t_q <= tgt_rdata;
		end
	end

	// black pixel lands in bin 0,0
	assign idx_pix = zero_q ? '0 :
		IDX_W'(IDX_W'(row) * IDX_W'(BINS_PER_AXIS) + IDX_W'(col));

	// counts saturate at 2^COUNT_BITS, the only value with the top bit set
	assign cnt_inc   = cnt_rdata[CNT_W-1] ? cnt_rdata : cnt_rdata + CNT_W'(1);
	assign cnt_raddr = cmd.cnt_rd ? idx_pix : idx_q;
	assign cnt_we    = cmd.clr_wr || cmd.cnt_wr || cmd.sw_wr;
	assign cnt_waddr = cmd.cnt_wr ? idx_pix : idx_q;
	assign cnt_wdata = cmd.cnt_wr ? cnt_inc : '0;

	rgchi_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign tgt_we    = cmd.clr_wr || (cmd.sw_wr && !req_q);
	assign tgt_wdata = cmd.clr_wr ? '0 : norm;

	rgchi_ram #(.WIDTH(VAL_W), .DEPTH(NUM_BINS)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (idx_q),
		.wdata (tgt_wdata),
		.raddr (idx_q),
		.rdata (tgt_rdata)
	);

	rgchi_div #(.XW(NX_W), .DW(CNT_W), .QW(VAL_W)) u_div_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.norm_start),
		.dividend ({cnt_rdata, {FRACTION_BITS{1'b0}}}),
		.divisor  (total_q),
		.quotient (norm),
		.done     (norm_done)
	);

	assign min_v   = (norm < t_q) ? norm : t_q;
	assign acc_sum = acc_q + ACC_W'(min_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			total_q   <= '0;
			acc_q     <= '0;
			tvalid_q  <= 1'b0;
			result_q  <= '0;
			tloaded_q <= 1'b0;
		end else begin
			if (cmd.idx_step) begin
				idx_q <= st.idx_last ? '0 : idx_q + IDX_W'(1);
			end
			if (cmd.total_clr) begin
				total_q <= '0;
			end else if (cmd.cnt_wr && !total_q[CNT_W-1]) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (cmd.acc_clr) begin
				acc_q <= '0;
			end else if (cmd.sw_wr) begin
				acc_q <= (acc_sum > OUT_MAX) ? OUT_MAX : acc_sum;
			end
			if (cmd.set_valid) begin
				tvalid_q <= 1'b1;
			end
			if (cmd.out_load) begin
				result_q  <= OUT_W'(acc_q);
				tloaded_q <= tvalid_q;
			end
		end
	end

	assign st.bin_done  = row_done && col_done;
	assign st.norm_done = norm_done;
	assign st.idx_last  = (idx_q == IDX_W'(NUM_BINS - 1));
	assign st.req       = req_q;
	assign st.last      = last_q;

	assign intersection  = result_q;
	assign target_loaded = tloaded_q;

endmodule

// ===== rtl/core/rg_chroma_histogram_intersection_top.sv =====
// Bins each pixel by rg chromaticity into a BINS_PER_AXIS^2 histogram held in ram. For each
// pixel the row and column dividers each yield one quotient bit per cycle, then the count is
// updated by a read-modify-write; no new pixel is taken until that is done. The last pixel of
// an image starts a sweep over every bin through the bit-serial normalize divider, which stores
// the target histogram or yields the intersection word. After reset a clearing pass zeroes
// both memories before the first pixel is taken.
// depends on rgchi_pkg, rgchi_ctrl, rgchi_dp
module rg_chroma_histogram_intersection_top
	import rgchi_pkg::*;
#(
	parameter int BINS_PER_AXIS = BINS_PER_AXIS_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [CHAN_W-1:0] blue,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] red,
	input  logic              last_pixel,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  intersection,
	output logic              target_loaded
);

	cmd_t    cmd;
	status_t st;

	rgchi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rgchi_dp #(
		.BINS_PER_AXIS (BINS_PER_AXIS),
		.COUNT_BITS    (COUNT_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.req_type      (req_type),
		.blue          (blue),
		.green         (green),
		.red           (red),
		.last_pixel    (last_pixel),
		.intersection  (intersection),
		.target_loaded (target_loaded)
	);

endmodule
